// ===== rtl/lsc_pkg.sv =====
// Shared types, constants and helpers for the load/store core with row buffer timing.
// No dependencies; every other file except lsc_ram uses this package by scoped names.
`default_nettype none
package lsc_pkg;

  localparam int MEM_BYTES = 1048576;
  localparam int ROW_BYTES = 1024;
  localparam int MEM_WORDS = MEM_BYTES / 4;
  localparam int MW_BITS = $clog2(MEM_WORDS);
  localparam int ROW_SHIFT = $clog2(ROW_BYTES);
  localparam int ROW_W = (MEM_BYTES > ROW_BYTES) ? $clog2(MEM_BYTES / ROW_BYTES) : 1;

  localparam int DW = 32;
  localparam int NREGS = 32;
  localparam int RW = $clog2(NREGS);
  localparam logic [RW-1:0] SP_REG = RW'(29);
  localparam logic [RW-1:0] LAST_REG = RW'(NREGS - 1);
  localparam logic [DW-1:0] SP_RESET = 32'd1048576;

  localparam int RD_W = 10;
  localparam int CD_W = 10;
  localparam int CODE_W = 19;
  localparam int CFG_DW = 19;
  localparam int CFG_IW = 2;
  localparam int DLY_W = 12;
  localparam logic [DLY_W-1:0] DLY_ONE = DLY_W'(1);
  localparam logic [DLY_W-1:0] DLY_TWO = DLY_W'(2);

  localparam int Q_DEPTH = 2;
  localparam int Q_PW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {CMD_ADD, CMD_ADDI, CMD_LW, CMD_SW} cmd_t;

  typedef enum logic [2:0] {
    ST_OK, ST_BAD_REG, ST_MISALIGN, ST_CODE, ST_BOUND, ST_HALTED
  } status_t;

  typedef enum logic [1:0] {EV_NONE, EV_FIRST, EV_HIT, EV_MISS} ev_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ROW_DELAY, CFG_COL_DELAY, CFG_CODE_WORDS
  } cfg_idx_t;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_MEM} state_t;

  typedef struct packed {
    cmd_t               command;
    logic [RW-1:0]      target_reg;
    logic [RW-1:0]      base_reg;
    logic [RW-1:0]      other_reg;
    logic signed [15:0] immediate;
    logic               is_mem;
    logic               is_load;
  } item_t;

  typedef struct packed {
    logic [31:0]        cycle_stamp;
    logic signed [31:0] written_value;
    logic               overlapped;
    ev_t                row_event;
    logic [31:0]        row_updates;
    status_t            status;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fe_out_t;

  typedef struct packed {
    logic take;
    logic clearing;
  } bk_ctl_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [DLY_W-1:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {{(33-DLY_W){1'b0}}, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/lsc_front.sv =====
// Front end: accepts items into a short queue and classifies them.
// Depends on lsc_pkg.
`default_nettype none
module lsc_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output      logic                  full,
  input  wire logic [1:0]            command,
  input  wire logic [4:0]            target_reg,
  input  wire logic [4:0]            base_reg,
  input  wire logic [4:0]            other_reg,
  input  wire logic signed [15:0]    immediate,
  input  wire lsc_pkg::bk_ctl_t      ctl,
  output      lsc_pkg::fe_out_t      fe
);

  lsc_pkg::item_t              q [lsc_pkg::Q_DEPTH];
  logic [lsc_pkg::Q_PW-1:0]    wr_ptr;
  logic [lsc_pkg::Q_PW-1:0]    rd_ptr;
  logic [lsc_pkg::Q_CW-1:0]    cnt;
  lsc_pkg::item_t              item_in;
  logic                        do_push;
  logic                        q_full;

  assign q_full = (cnt == lsc_pkg::Q_CW'(lsc_pkg::Q_DEPTH));
  assign full = q_full || ctl.clearing;
  assign do_push = push && !full;

  always_comb begin
    item_in.command    = lsc_pkg::cmd_t'(command);
    item_in.target_reg = target_reg;
    item_in.base_reg   = base_reg;
    item_in.other_reg  = other_reg;
    item_in.immediate  = immediate;
    item_in.is_mem     = command[1];
    item_in.is_load    = (lsc_pkg::cmd_t'(command) == lsc_pkg::CMD_LW);
  end

  assign fe.valid = (cnt != '0);
  assign fe.item = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (ctl.take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !ctl.take) begin
        cnt <= cnt + 1'b1;
      end else if (!do_push && ctl.take) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lsc_resq.sv =====
// Result queue between the executor and the result ports.
// Depends on lsc_pkg.
`default_nettype none
module lsc_resq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  wire lsc_pkg::result_t  din,
  output      logic              full,
  input  wire logic              pop,
  output      logic              empty,
  output      lsc_pkg::result_t  head
);

  lsc_pkg::result_t            q [lsc_pkg::Q_DEPTH];
  logic [lsc_pkg::Q_PW-1:0]    wr_ptr;
  logic [lsc_pkg::Q_PW-1:0]    rd_ptr;
  logic [lsc_pkg::Q_CW-1:0]    cnt;
  logic                        do_pop;

  assign full = (cnt == lsc_pkg::Q_CW'(lsc_pkg::Q_DEPTH));
  assign empty = (cnt == '0);
  assign do_pop = pop && !empty;
  assign head = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (!wr && do_pop) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lsc_back.sv =====
// Back end: executes one item at a time, keeps register file, data memory and timing state.
// Depends on lsc_pkg and lsc_ram.
`default_nettype none
module lsc_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [lsc_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [lsc_pkg::CFG_DW-1:0]    cfg_data,
  input  wire lsc_pkg::fe_out_t              fe,
  output      lsc_pkg::bk_ctl_t              ctl,
  input  wire logic                          rq_full,
  output      logic                          res_wr,
  output      lsc_pkg::result_t              res
);

  lsc_pkg::state_t                 state;
  lsc_pkg::state_t                 state_next;
  lsc_pkg::item_t                  item_q;
  logic [lsc_pkg::RD_W-1:0]        row_delay;
  logic [lsc_pkg::CD_W-1:0]        col_delay;
  logic [lsc_pkg::CODE_W-1:0]      code_words;
  logic [lsc_pkg::NREGS-1:0]       rf_valid;
  logic                            row_open;
  logic [lsc_pkg::ROW_W-1:0]       open_row;
  logic [31:0]                     cycle_count;
  logic [31:0]                     update_count;
  logic [lsc_pkg::DLY_W-1:0]       shadow_left;
  logic [31:0]                     shadow_stamp;
  logic [lsc_pkg::RW-1:0]          pending_reg;
  logic                            pending_is_load;
  logic                            halted;
  logic [lsc_pkg::MW_BITS-1:0]     clr_cnt;
  logic [lsc_pkg::ROW_W-1:0]       row_q;
  logic [31:0]                     val_q;

  logic                            row_open_next;
  logic [lsc_pkg::ROW_W-1:0]       open_row_next;
  logic [31:0]                     cycle_count_next;
  logic [31:0]                     update_count_next;
  logic [lsc_pkg::DLY_W-1:0]       shadow_left_next;
  logic [31:0]                     shadow_stamp_next;
  logic [lsc_pkg::RW-1:0]          pending_reg_next;
  logic                            pending_is_load_next;
  logic                            halted_next;

  logic [lsc_pkg::RW-1:0]          rf_raddr_b;
  logic [31:0]                     rf_rdata_a;
  logic [31:0]                     rf_rdata_b;
  logic                            rf_we;
  logic [lsc_pkg::RW-1:0]          rf_waddr;
  logic [31:0]                     rf_wdata;
  logic                            dm_we;
  logic [lsc_pkg::MW_BITS-1:0]     dm_waddr;
  logic [31:0]                     dm_wdata;
  logic [31:0]                     dm_rdata;

  logic [lsc_pkg::RW-1:0]          b_reg_q;
  logic [31:0]                     opa;
  logic [31:0]                     opb;
  logic [31:0]                     imm_ext;
  logic [31:0]                     alu_val;
  logic [31:0]                     addr;
  logic                            dep;
  logic                            exec_err;
  lsc_pkg::status_t                err_st;
  logic                            clr_done;

  logic [lsc_pkg::DLY_W-1:0]       delay;
  logic [lsc_pkg::DLY_W-1:0]       upd_inc;
  lsc_pkg::ev_t                    ev;
  logic [31:0]                     issue_cc;

  assign ctl.take = (state == lsc_pkg::S_IDLE) && fe.valid && !rq_full;
  assign ctl.clearing = (state == lsc_pkg::S_CLEAR);
  assign clr_done = (clr_cnt == lsc_pkg::MW_BITS'(lsc_pkg::MEM_WORDS - 1));

  assign rf_raddr_b = (fe.item.command == lsc_pkg::CMD_ADD) ? fe.item.other_reg
                                                            : fe.item.target_reg;
  assign b_reg_q = (item_q.command == lsc_pkg::CMD_ADD) ? item_q.other_reg
                                                        : item_q.target_reg;

  lsc_ram #(.WIDTH(32), .DEPTH(lsc_pkg::NREGS)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(fe.item.base_reg), .rdata(rf_rdata_a)
  );

  lsc_ram #(.WIDTH(32), .DEPTH(lsc_pkg::NREGS)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr_b), .rdata(rf_rdata_b)
  );

  lsc_ram #(.WIDTH(32), .DEPTH(lsc_pkg::MEM_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(addr[2 +: lsc_pkg::MW_BITS]), .rdata(dm_rdata)
  );

  // operands and checks, valid in S_EXEC
  always_comb begin
    opa = rf_valid[item_q.base_reg] ? rf_rdata_a
        : ((item_q.base_reg == lsc_pkg::SP_REG) ? lsc_pkg::SP_RESET : '0);
    opb = rf_valid[b_reg_q] ? rf_rdata_b
        : ((b_reg_q == lsc_pkg::SP_REG) ? lsc_pkg::SP_RESET : '0);
    imm_ext = {{16{item_q.immediate[15]}}, item_q.immediate};
    alu_val = opa + ((item_q.command == lsc_pkg::CMD_ADD) ? opb : imm_ext);
    addr = opa + imm_ext;
    dep = 1'b0;
    if (shadow_left != '0) begin
      if (pending_is_load) begin
        dep = (item_q.target_reg == pending_reg) || (item_q.base_reg == pending_reg) ||
              ((item_q.command == lsc_pkg::CMD_ADD) && (item_q.other_reg == pending_reg));
      end else begin
        dep = (item_q.target_reg == pending_reg);
      end
    end
    exec_err = 1'b1;
    if ((item_q.target_reg == '0) ||
        ((item_q.command == lsc_pkg::CMD_SW) && (item_q.target_reg == lsc_pkg::LAST_REG))) begin
      err_st = lsc_pkg::ST_BAD_REG;
    end else if (!item_q.is_mem) begin
      err_st = lsc_pkg::ST_OK;
      exec_err = 1'b0;
    end else if (addr[1:0] != 2'b00) begin
      err_st = lsc_pkg::ST_MISALIGN;
    end else if (addr[31] || (addr < {11'b0, code_words, 2'b00})) begin
      err_st = lsc_pkg::ST_CODE;
    end else if (addr >= 32'(lsc_pkg::MEM_BYTES)) begin
      err_st = lsc_pkg::ST_BOUND;
    end else begin
      err_st = lsc_pkg::ST_OK;
      exec_err = 1'b0;
    end
  end

  // row timing, valid in S_MEM
  always_comb begin
    if (!row_open) begin
      ev = lsc_pkg::EV_FIRST;
      delay = lsc_pkg::DLY_W'(row_delay) + lsc_pkg::DLY_W'(col_delay);
    end else if (open_row == row_q) begin
      ev = lsc_pkg::EV_HIT;
      delay = lsc_pkg::DLY_W'(col_delay);
    end else begin
      ev = lsc_pkg::EV_MISS;
      delay = (lsc_pkg::DLY_W'(row_delay) << 1) + lsc_pkg::DLY_W'(col_delay);
    end
    if (item_q.is_load) begin
      upd_inc = (ev == lsc_pkg::EV_HIT) ? '0 : lsc_pkg::DLY_ONE;
    end else begin
      upd_inc = (ev == lsc_pkg::EV_HIT) ? lsc_pkg::DLY_ONE : lsc_pkg::DLY_TWO;
    end
    issue_cc = lsc_pkg::sat_add(cycle_count, lsc_pkg::DLY_ONE);
  end

  always_comb begin
    state_next = state;
    case (state)
      lsc_pkg::S_CLEAR: begin
        if (clr_done) begin
          state_next = lsc_pkg::S_IDLE;
        end
      end
      lsc_pkg::S_IDLE: begin
        if (ctl.take) begin
          state_next = lsc_pkg::S_EXEC;
        end
      end
      lsc_pkg::S_EXEC: begin
        if (!halted && item_q.is_mem && !exec_err) begin
          state_next = lsc_pkg::S_MEM;
        end else begin
          state_next = lsc_pkg::S_IDLE;
        end
      end
      lsc_pkg::S_MEM: state_next = lsc_pkg::S_IDLE;
      default: state_next = lsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    row_open_next = row_open;
    open_row_next = open_row;
    cycle_count_next = cycle_count;
    update_count_next = update_count;
    shadow_left_next = shadow_left;
    shadow_stamp_next = shadow_stamp;
    pending_reg_next = pending_reg;
    pending_is_load_next = pending_is_load;
    halted_next = halted;
    rf_we = 1'b0;
    rf_waddr = item_q.target_reg;
    rf_wdata = alu_val;
    dm_we = 1'b0;
    dm_waddr = addr[2 +: lsc_pkg::MW_BITS];
    dm_wdata = opb;
    res_wr = 1'b0;
    res.cycle_stamp = cycle_count;
    res.written_value = '0;
    res.overlapped = 1'b0;
    res.row_event = lsc_pkg::EV_NONE;
    res.row_updates = update_count;
    res.status = lsc_pkg::ST_HALTED;
    case (state)
      lsc_pkg::S_CLEAR: begin
        dm_we = 1'b1;
        dm_waddr = clr_cnt;
        dm_wdata = '0;
      end
      lsc_pkg::S_EXEC: begin
        res_wr = 1'b1;
        if (halted) begin
          res.status = lsc_pkg::ST_HALTED;
        end else if (exec_err) begin
          halted_next = 1'b1;
          shadow_left_next = '0;
          res.status = err_st;
        end else if (!item_q.is_mem) begin
          rf_we = 1'b1;
          res.written_value = alu_val;
          res.status = lsc_pkg::ST_OK;
          if (!dep && (shadow_left != '0)) begin
            res.cycle_stamp = shadow_stamp;
            res.overlapped = 1'b1;
            shadow_stamp_next = lsc_pkg::sat_add(shadow_stamp, lsc_pkg::DLY_ONE);
            shadow_left_next = shadow_left - 1'b1;
          end else begin
            shadow_left_next = '0;
            cycle_count_next = issue_cc;
            res.cycle_stamp = issue_cc;
          end
        end else begin
          res_wr = 1'b0;
          shadow_left_next = '0;
          dm_we = !item_q.is_load;
        end
      end
      lsc_pkg::S_MEM: begin
        res_wr = 1'b1;
        row_open_next = 1'b1;
        open_row_next = row_q;
        update_count_next = lsc_pkg::sat_add(update_count, upd_inc);
        shadow_stamp_next = lsc_pkg::sat_add(issue_cc, lsc_pkg::DLY_ONE);
        cycle_count_next = lsc_pkg::sat_add(issue_cc, delay);
        shadow_left_next = delay;
        pending_reg_next = item_q.target_reg;
        pending_is_load_next = item_q.is_load;
        rf_we = item_q.is_load;
        rf_wdata = dm_rdata;
        res.cycle_stamp = cycle_count_next;
        res.written_value = item_q.is_load ? dm_rdata : val_q;
        res.row_event = ev;
        res.row_updates = update_count_next;
        res.status = lsc_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      item_q <= fe.item;
    end
    if (state == lsc_pkg::S_EXEC) begin
      row_q <= addr[lsc_pkg::ROW_SHIFT +: lsc_pkg::ROW_W];
      val_q <= opb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsc_pkg::S_CLEAR;
      row_delay <= lsc_pkg::RD_W'(10);
      col_delay <= lsc_pkg::CD_W'(2);
      code_words <= '0;
      rf_valid <= '0;
      row_open <= 1'b0;
      open_row <= '0;
      cycle_count <= '0;
      update_count <= '0;
      shadow_left <= '0;
      shadow_stamp <= '0;
      pending_reg <= '0;
      pending_is_load <= 1'b0;
      halted <= 1'b0;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      row_open <= row_open_next;
      open_row <= open_row_next;
      cycle_count <= cycle_count_next;
      update_count <= update_count_next;
      shadow_left <= shadow_left_next;
      shadow_stamp <= shadow_stamp_next;
      pending_reg <= pending_reg_next;
      pending_is_load <= pending_is_load_next;
      halted <= halted_next;
      if (state == lsc_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (rf_we) begin
        rf_valid[rf_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          lsc_pkg::CFG_ROW_DELAY:  row_delay <= cfg_data[lsc_pkg::RD_W-1:0];
          lsc_pkg::CFG_COL_DELAY:  col_delay <= cfg_data[lsc_pkg::CD_W-1:0];
          lsc_pkg::CFG_CODE_WORDS: code_words <= cfg_data[lsc_pkg::CODE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_halt_no_shadow: assert property (@(posedge clk) disable iff (rst)
    halted |-> (shadow_left == '0))
    else $error("shadow left open after halt");
  a_mem_after_exec: assert property (@(posedge clk) disable iff (rst)
    (state == lsc_pkg::S_MEM) |-> ($past(state) == lsc_pkg::S_EXEC))
    else $error("memory phase without execute phase");
  a_no_r0_write: assert property (@(posedge clk) disable iff (rst)
    rf_we |-> (rf_waddr != '0))
    else $error("write to register zero");
  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    (state == lsc_pkg::S_CLEAR) |-> !ctl.take)
    else $error("item taken during memory clear");
  a_res_space: assert property (@(posedge clk) disable iff (rst)
    res_wr |-> !rq_full)
    else $error("result written into full queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/load_store_core_with_row_buffer_timing.sv =====
// Load/store core with DRAM row buffer timing: input queue, executor and result queue.
// After reset the data memory is cleared one word per cycle, during which full stays
// high; configuration writes are taken throughout. add/addi pass through the executor
// as a register file read, then execute; lw/sw add a further step for the synchronous
// data memory access. Two-entry queues on both sides let input and output stall
// independently. Depends on lsc_pkg, lsc_front, lsc_back, lsc_resq and lsc_ram.
`default_nettype none
module load_store_core_with_row_buffer_timing (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output      logic                        full,
  input  wire logic [1:0]                  command,
  input  wire logic [4:0]                  target_reg,
  input  wire logic [4:0]                  base_reg,
  input  wire logic [4:0]                  other_reg,
  input  wire logic signed [15:0]          immediate,
  output      logic                        empty,
  input  wire logic                        pop,
  output      logic [31:0]                 cycle_stamp,
  output      logic signed [31:0]          written_value,
  output      logic                        overlapped,
  output      logic [1:0]                  row_event,
  output      logic [31:0]                 row_updates,
  output      logic [2:0]                  status,
  input  wire logic                        cfg_we,
  input  wire logic [lsc_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [lsc_pkg::CFG_DW-1:0]  cfg_data
);

  lsc_pkg::fe_out_t  fe;
  lsc_pkg::bk_ctl_t  ctl;
  lsc_pkg::result_t  res;
  lsc_pkg::result_t  head;
  logic              res_wr;
  logic              rq_full;

  lsc_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .command(command), .target_reg(target_reg), .base_reg(base_reg),
    .other_reg(other_reg), .immediate(immediate), .ctl(ctl), .fe(fe)
  );

  lsc_back u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fe(fe), .ctl(ctl), .rq_full(rq_full), .res_wr(res_wr), .res(res)
  );

  lsc_resq u_resq (
    .clk(clk), .rst(rst), .wr(res_wr), .din(res), .full(rq_full),
    .pop(pop), .empty(empty), .head(head)
  );

  assign cycle_stamp = head.cycle_stamp;
  assign written_value = head.written_value;
  assign overlapped = head.overlapped;
  assign row_event = head.row_event;
  assign row_updates = head.row_updates;
  assign status = head.status;

endmodule
`default_nettype wire
